### src/stlx_pkg.sv
// shared types, character codes and classifier functions for the script token lexer
// no dependencies; imported by every lexer module
`default_nettype none
package stlx_pkg;

  localparam int unsigned RowBitsDef = 16;
  localparam int unsigned ColBitsDef = 16;
  localparam int unsigned QDepth     = 4;
  localparam int unsigned QPtrW      = $clog2(QDepth);

  localparam logic [7:0] CH_TAB = 8'h09;
  localparam logic [7:0] CH_LF  = 8'h0A;
  localparam logic [7:0] CH_CR  = 8'h0D;
  localparam logic [7:0] CH_SP  = 8'h20;
  localparam logic [7:0] CH_BANG = 8'h21;
  localparam logic [7:0] CH_DQ  = 8'h22;
  localparam logic [7:0] CH_HASH = 8'h23;
  localparam logic [7:0] CH_STAR = 8'h2A;
  localparam logic [7:0] CH_DASH = 8'h2D;
  localparam logic [7:0] CH_DOT = 8'h2E;
  localparam logic [7:0] CH_SLASH = 8'h2F;
  localparam logic [7:0] CH_SEMI = 8'h3B;
  localparam logic [7:0] CH_LT  = 8'h3C;
  localparam logic [7:0] CH_GT  = 8'h3E;
  localparam logic [7:0] CH_BSL = 8'h5C;
  localparam logic [7:0] CH_LC_N = 8'h6E;
  localparam logic [7:0] CH_LC_T = 8'h74;

  localparam logic [5:0] K_NAME  = 6'd0;
  localparam logic [5:0] K_STR   = 6'd1;
  localparam logic [5:0] K_INT   = 6'd2;
  localparam logic [5:0] K_FLT   = 6'd3;
  localparam logic [5:0] K_BLANK = 6'd4;
  localparam logic [5:0] K_TAB   = 6'd5;
  localparam logic [5:0] K_NL    = 6'd6;
  localparam logic [5:0] K_EOF   = 6'd34;

  localparam logic [1:0] ERR_NONE    = 2'd0;
  localparam logic [1:0] ERR_ESCAPE  = 2'd1;
  localparam logic [1:0] ERR_TWO_DOT = 2'd2;
  localparam logic [1:0] ERR_DOT     = 2'd3;

  localparam logic [2:0] STYLE_C    = 3'd1;
  localparam logic [2:0] STYLE_HTML = 3'd2;
  localparam logic [2:0] STYLE_HASH = 3'd3;
  localparam logic [2:0] STYLE_SEMI = 3'd4;

  localparam logic REG_STYLE = 1'b0;
  localparam logic REG_IGNWS = 1'b1;

  typedef enum logic [2:0] {
    M_IDLE, M_NAME, M_NUM, M_STR, M_ESC, M_LINE, M_BLOCK
  } mode_e;

  typedef enum logic [1:0] {
    JOB_BYTE, JOB_FLUSH, JOB_EOF
  } job_kind_e;

  typedef struct packed {
    job_kind_e  kind;
    logic [7:0] b;
    logic [7:0] n1;
    logic [7:0] n2;
    logic [7:0] n3;
  } job_t;

  typedef struct packed {
    logic [7:0]  ch;
    logic        txt;
    logic        tend;
    logic [5:0]  kind;
    logic [15:0] row;
    logic [15:0] col;
    logic [1:0]  err;
    logic        last;
  } res_t;

  function automatic logic is_name(input logic [7:0] c);
    return (c >= 8'h61 && c <= 8'h7A) || (c >= 8'h41 && c <= 8'h5A) || c == 8'h5F;
  endfunction

  function automatic logic is_digit(input logic [7:0] c);
    return c >= 8'h30 && c <= 8'h39;
  endfunction

  function automatic res_t mk_res(input logic [7:0] ch, input logic txt, input logic tend,
                                  input logic [5:0] kind, input logic [1:0] err);
    res_t r;
    r      = '0;
    r.ch   = ch;
    r.txt  = txt;
    r.tend = tend;
    r.kind = kind;
    r.err  = err;
    return r;
  endfunction

  // sign token kind, zero when the byte is no sign
  function automatic logic [5:0] sign_kind(input logic [7:0] c);
    logic [5:0] k;
    case (c)
      8'h2C:   k = 6'd7;   // ,
      8'h2E:   k = 6'd8;   // .
      8'h3A:   k = 6'd9;   // :
      8'h3B:   k = 6'd10;  // ;
      8'h21:   k = 6'd11;  // !
      8'h3F:   k = 6'd12;  // ?
      8'h23:   k = 6'd13;  // #
      8'h40:   k = 6'd14;  // @
      8'h24:   k = 6'd15;  // $
      8'h28:   k = 6'd16;
      8'h29:   k = 6'd17;
      8'h5B:   k = 6'd18;
      8'h5D:   k = 6'd19;
      8'h7B:   k = 6'd20;
      8'h7D:   k = 6'd21;
      8'h3E:   k = 6'd22;
      8'h3C:   k = 6'd23;
      8'h3D:   k = 6'd24;
      8'h2B:   k = 6'd25;
      8'h2D:   k = 6'd26;
      8'h2A:   k = 6'd27;
      8'h2F:   k = 6'd28;
      8'h25:   k = 6'd29;
      8'h7E:   k = 6'd30;
      8'h26:   k = 6'd31;
      8'h7C:   k = 6'd32;
      8'h5E:   k = 6'd33;
      default: k = 6'd0;
    endcase
    return k;
  endfunction

endpackage
`default_nettype wire

### src/stlx_front.sv
// front end: input byte acceptance, three-byte lookahead and flush sequencing
// depends on stlx_pkg; feeds lexer jobs into stlx_queue
`default_nettype none
module stlx_front (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire logic         in_valid_i,
  output logic              in_ready_o,
  input  wire logic [7:0]   in_char_i,
  input  wire logic         in_last_i,
  input  wire logic         q_full_i,
  output logic              push_o,
  output stlx_pkg::job_t    job_o
);
  import stlx_pkg::*;

  logic [7:0] la_q [3];
  logic [7:0] la_d [3];
  logic [1:0] cnt_q, cnt_d;
  logic [7:0] fb_q [4];
  logic [7:0] fb_d [4];
  logic [2:0] fl_q, fl_d;   // jobs left in a flush, eof job included
  logic       acc;

  assign in_ready_o = (fl_q == 3'd0) && !q_full_i;
  assign acc        = in_valid_i && in_ready_o;

  always_comb begin
    la_d   = la_q;
    cnt_d  = cnt_q;
    fb_d   = fb_q;
    fl_d   = fl_q;
    push_o = 1'b0;
    job_o  = '{kind: JOB_BYTE, b: la_q[0], n1: la_q[1], n2: la_q[2], n3: in_char_i};
    if (fl_q != 3'd0) begin
      job_o = '{kind: (fl_q == 3'd1) ? JOB_EOF : JOB_FLUSH,
                b: fb_q[0], n1: fb_q[1], n2: fb_q[2], n3: fb_q[3]};
      if (!q_full_i) begin
        push_o = 1'b1;
        fl_d   = fl_q - 3'd1;
        fb_d   = '{fb_q[1], fb_q[2], fb_q[3], 8'h00};
      end
    end else if (acc) begin
      if (in_last_i) begin
        for (int i = 0; i < 4; i++) begin
          if (i < int'(cnt_q))       fb_d[i] = la_q[i];
          else if (i == int'(cnt_q)) fb_d[i] = in_char_i;
          else                       fb_d[i] = 8'h00;
        end
        fl_d  = 3'(cnt_q) + 3'd2;
        cnt_d = 2'd0;
      end else if (cnt_q != 2'd3) begin
        la_d[cnt_q] = in_char_i;
        cnt_d       = cnt_q + 2'd1;
      end else begin
        push_o = 1'b1;
        la_d   = '{la_q[1], la_q[2], in_char_i};
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= 2'd0;
      fl_q  <= 3'd0;
    end else begin
      cnt_q <= cnt_d;
      fl_q  <= fl_d;
    end
  end

  always_ff @(posedge clk_i) begin
    la_q <= la_d;
    fb_q <= fb_d;
  end

endmodule
`default_nettype wire

### src/stlx_queue.sv
// short job queue between the lexer front and back
// depends on stlx_pkg for the job type and depth
`default_nettype none
module stlx_queue (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           push_i,
  input  wire stlx_pkg::job_t job_i,
  output logic                full_o,
  output logic                valid_o,
  input  wire logic           pop_i,
  output stlx_pkg::job_t      job_o
);
  import stlx_pkg::*;

  job_t                 mem_q [QDepth];
  logic [QPtrW-1:0]     wp_q, rp_q;
  logic [QPtrW:0]       cnt_q;

  assign full_o  = cnt_q == (QPtrW+1)'(QDepth);
  assign valid_o = cnt_q != '0;
  assign job_o   = mem_q[rp_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= '0;
      rp_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push_i) wp_q <= wp_q + 1'b1;
      if (pop_i)  rp_q <= rp_q + 1'b1;
      cnt_q <= cnt_q + (QPtrW+1)'(push_i) - (QPtrW+1)'(pop_i);
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wp_q] <= job_i;
  end

endmodule
`default_nettype wire

### src/stlx_back.sv
// back end: lexer mode machine, position counters and two-slot result buffer
// depends on stlx_pkg; takes jobs from stlx_queue
`default_nettype none
module stlx_back #(
  parameter int unsigned ROW_BITS = stlx_pkg::RowBitsDef,
  parameter int unsigned COL_BITS = stlx_pkg::ColBitsDef
) (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic [2:0]     style_i,
  input  wire logic           ignws_i,
  input  wire logic           job_valid_i,
  input  wire stlx_pkg::job_t job_i,
  output logic                pop_o,
  output logic                out_valid_o,
  input  wire logic           out_ready_i,
  output stlx_pkg::res_t      res_o
);
  import stlx_pkg::*;

  mode_e               mode_q, mode_d;
  logic                dot_q, dot_d, dot_cur;
  logic [1:0]          skip_q, skip_d;
  logic [ROW_BITS-1:0] row_q, row_d, row_inc;
  logic [COL_BITS-1:0] col_q, col_d, col_inc;
  logic                err_q, err_d;
  logic [1:0]          ocnt_q, ocnt_d;
  res_t                slot_q [2];
  res_t                slot_d [2];
  res_t                pr [2];
  logic [1:0]          pn;
  logic                ws_hit;
  res_t                ws_res;
  logic [5:0]          sk;
  logic                take;
  logic [7:0]          b, n1, n2, n3;

  assign b  = job_i.b;
  assign n1 = job_i.n1;
  assign n2 = job_i.n2;
  assign n3 = job_i.n3;

  assign out_valid_o = ocnt_q != 2'd0;
  assign res_o       = slot_q[0];
  assign take        = ocnt_q == 2'd0 || (ocnt_q == 2'd1 && out_ready_i);
  assign pop_o       = job_valid_i && take;

  assign row_inc = (row_q != {ROW_BITS{1'b1}}) ? row_q + 1'b1 : row_q;
  assign col_inc = (col_q != {COL_BITS{1'b1}}) ? col_q + 1'b1 : col_q;
  assign sk      = sign_kind(b);

  always_comb begin
    ws_hit = !ignws_i && (b == CH_SP || b == CH_TAB || b == CH_LF);
    ws_res = mk_res(b, 1'b0, 1'b1,
                    (b == CH_SP) ? K_BLANK : ((b == CH_TAB) ? K_TAB : K_NL), ERR_NONE);
  end

  always_comb begin
    mode_d  = mode_q;
    dot_d   = dot_q;
    skip_d  = skip_q;
    row_d   = row_q;
    col_d   = col_q;
    err_d   = err_q;
    pr[0]   = '0;
    pr[1]   = '0;
    pn      = 2'd0;
    dot_cur = (mode_q == M_NUM) ? dot_q : 1'b0;
    if (pop_o && !err_q) begin
      if (job_i.kind == JOB_EOF) begin
        if (mode_q == M_ESC && skip_q == 2'd0) begin
          pr[0] = mk_res(8'h00, 1'b0, 1'b0, K_NAME, ERR_ESCAPE);
          err_d = 1'b1;
        end else begin
          pr[0]  = mk_res(8'h00, 1'b0, 1'b1, K_EOF, ERR_NONE);
          mode_d = M_IDLE;
          dot_d  = 1'b0;
          skip_d = 2'd0;
          row_d  = ROW_BITS'(1);
          col_d  = COL_BITS'(1);
        end
        pr[0].last = 1'b1;
        pn         = 2'd1;
      end else begin
        col_d = (b == CH_LF) ? COL_BITS'(1) : col_inc;
        row_d = (b == CH_LF) ? row_inc : row_q;
        if (skip_q != 2'd0) begin
          skip_d = skip_q - 2'd1;
        end else begin
          case (mode_q)
            M_LINE: begin
              if (b == CH_LF) begin
                mode_d = M_IDLE;
                if (ws_hit) begin
                  pr[0] = ws_res;
                  pn    = 2'd1;
                end
              end
            end
            M_BLOCK: begin
              if (style_i == STYLE_HTML) begin
                if (b == CH_DASH && n1 == CH_DASH && n2 == CH_GT) begin
                  mode_d = M_IDLE;
                  skip_d = 2'd2;
                end
              end else if (b == CH_STAR && n1 == CH_SLASH) begin
                mode_d = M_IDLE;
                skip_d = 2'd1;
              end
            end
            M_ESC: begin
              if (b == CH_LC_T || b == CH_LC_N || b == CH_DQ) begin
                pr[0]  = mk_res((b == CH_LC_T) ? CH_TAB : ((b == CH_LC_N) ? CH_LF : CH_DQ),
                                1'b1, 1'b0, K_NAME, ERR_NONE);
                pn     = 2'd1;
                mode_d = M_STR;
              end else begin
                pr[0]      = mk_res(8'h00, 1'b0, 1'b0, K_NAME, ERR_ESCAPE);
                pr[0].last = 1'b1;
                pn         = 2'd1;
                err_d      = 1'b1;
              end
            end
            M_STR: begin
              if (b == CH_BSL) begin
                mode_d = M_ESC;
              end else if (b == CH_DQ) begin
                mode_d = M_IDLE;
                pr[0]  = mk_res(8'h00, 1'b0, 1'b1, K_STR, ERR_NONE);
                pn     = 2'd1;
              end else begin
                pr[0] = mk_res(b, 1'b1, 1'b0, K_NAME, ERR_NONE);
                pn    = 2'd1;
              end
            end
            default: begin
              if (b == CH_DQ) begin
                mode_d = M_STR;
              end else if (style_i == STYLE_C && b == CH_SLASH &&
                           (n1 == CH_SLASH || n1 == CH_STAR)) begin
                mode_d = (n1 == CH_SLASH) ? M_LINE : M_BLOCK;
                skip_d = 2'd1;
              end else if (style_i == STYLE_HTML && b == CH_LT && n1 == CH_BANG &&
                           n2 == CH_DASH && n3 == CH_DASH) begin
                mode_d = M_BLOCK;
                skip_d = 2'd3;
              end else if ((style_i == STYLE_HASH && b == CH_HASH) ||
                           (style_i == STYLE_SEMI && b == CH_SEMI)) begin
                mode_d = M_LINE;
              end else if (b == CH_SP || b == CH_TAB || b == CH_CR || b == CH_LF) begin
                if (ws_hit) begin
                  pr[0] = ws_res;
                  pn    = 2'd1;
                end
              end else if (mode_q == M_NAME || is_name(b)) begin
                mode_d = M_NAME;
                pr[0]  = mk_res(b, 1'b1, 1'b0, K_NAME, ERR_NONE);
                pn     = 2'd1;
                if (!is_name(n1) && !is_digit(n1)) begin
                  mode_d = M_IDLE;
                  pr[1]  = mk_res(8'h00, 1'b0, 1'b1, K_NAME, ERR_NONE);
                  pn     = 2'd2;
                end
              end else if (mode_q == M_NUM || is_digit(b) ||
                           (b == CH_DOT && is_digit(n1))) begin
                mode_d = M_NUM;
                dot_d  = dot_cur;
                if (b == CH_DOT) begin
                  dot_d = 1'b1;
                  if (dot_cur || !is_digit(n1)) begin
                    pr[0]      = mk_res(8'h00, 1'b0, 1'b0, K_NAME,
                                        dot_cur ? ERR_TWO_DOT : ERR_DOT);
                    pr[0].last = 1'b1;
                    err_d      = 1'b1;
                  end else begin
                    pr[0] = mk_res(b, 1'b1, 1'b0, K_NAME, ERR_NONE);
                  end
                  pn = 2'd1;
                end else begin
                  pr[0] = mk_res(b, 1'b1, 1'b0, K_NAME, ERR_NONE);
                  pn    = 2'd1;
                  if (!is_digit(n1) && n1 != CH_DOT) begin
                    mode_d = M_IDLE;
                    pr[1]  = mk_res(8'h00, 1'b0, 1'b1, dot_cur ? K_FLT : K_INT, ERR_NONE);
                    pn     = 2'd2;
                  end
                end
              end else if (sk != 6'd0) begin
                pr[0] = mk_res(b, 1'b0, 1'b1, sk, ERR_NONE);
                pn    = 2'd1;
              end
            end
          endcase
        end
        // a plain byte closes its input transfer with its final result
        if (job_i.kind == JOB_BYTE) begin
          if (pn == 2'd1) pr[0].last = 1'b1;
          if (pn == 2'd2) pr[1].last = 1'b1;
        end
      end
    end
    // eof stamps the position before the counters clear
    for (int i = 0; i < 2; i++) begin
      pr[i].row = (job_i.kind == JOB_EOF) ? 16'(row_q) : 16'(row_d);
      pr[i].col = (job_i.kind == JOB_EOF) ? 16'(col_q) : 16'(col_d);
    end
  end

  always_comb begin
    slot_d = slot_q;
    ocnt_d = ocnt_q;
    if (pop_o) begin
      slot_d = pr;
      ocnt_d = err_q ? 2'd0 : pn;
    end else if (out_valid_o && out_ready_i) begin
      slot_d[0] = slot_q[1];
      ocnt_d    = ocnt_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= M_IDLE;
      dot_q  <= 1'b0;
      skip_q <= 2'd0;
      row_q  <= ROW_BITS'(1);
      col_q  <= COL_BITS'(1);
      err_q  <= 1'b0;
      ocnt_q <= 2'd0;
    end else begin
      mode_q <= mode_d;
      dot_q  <= dot_d;
      skip_q <= skip_d;
      row_q  <= row_d;
      col_q  <= col_d;
      err_q  <= err_d;
      ocnt_q <= ocnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    slot_q <= slot_d;
  end

endmodule
`default_nettype wire

### src/script_token_lexer_unit.sv
// a byte's job enters the queue when the byte three places later transfers; the back end
// pops it into its registered result slots, where a second result follows the first
// throughput: one byte per cycle while the queue is not full and no flush runs; a byte
// with two results holds the next job back; after a final byte the input waits for the flush
// reset: asynchronous active low; clears lookahead count, mode, counters, error flag, registers
// top level of the script token lexer; depends on stlx_pkg, stlx_front, stlx_queue, stlx_back
`default_nettype none
module script_token_lexer_unit #(
  parameter int unsigned ROW_BITS = stlx_pkg::RowBitsDef,
  parameter int unsigned COL_BITS = stlx_pkg::ColBitsDef
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        cfg_we_i,
  input  wire logic        cfg_idx_i,
  input  wire logic [2:0]  cfg_wdata_i,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [7:0]  s_axis_tdata,   // in_char
  input  wire logic        s_axis_tlast,   // in_last
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [39:0]      m_axis_tdata,   // out_char, row_pos, col_pos
  output logic [9:0]       m_axis_tuser,   // is_text, token_end, token_kind, error_code
  output logic             m_axis_tlast    // run_last
);
  import stlx_pkg::*;

  logic [2:0] style_q;
  logic       ignws_q;
  logic       push, full, qvalid, pop;
  job_t       push_job, pop_job;
  res_t       res;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      style_q <= 3'd0;
      ignws_q <= 1'b0;
    end else if (cfg_we_i) begin
      if (cfg_idx_i == REG_STYLE) style_q <= cfg_wdata_i;
      if (cfg_idx_i == REG_IGNWS) ignws_q <= cfg_wdata_i[0];
    end
  end

  stlx_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .in_char_i  (s_axis_tdata),
    .in_last_i  (s_axis_tlast),
    .q_full_i   (full),
    .push_o     (push),
    .job_o      (push_job)
  );

  stlx_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .job_i   (push_job),
    .full_o  (full),
    .valid_o (qvalid),
    .pop_i   (pop),
    .job_o   (pop_job)
  );

  stlx_back #(
    .ROW_BITS (ROW_BITS),
    .COL_BITS (COL_BITS)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .style_i     (style_q),
    .ignws_i     (ignws_q),
    .job_valid_i (qvalid),
    .job_i       (pop_job),
    .pop_o       (pop),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .res_o       (res)
  );

  assign m_axis_tdata = {res.col, res.row, res.ch};
  assign m_axis_tuser = {res.err, res.kind, res.tend, res.txt};
  assign m_axis_tlast = res.last;

endmodule
`default_nettype wire

### src/stlx_checker.sv
// port-level checks for the script token lexer, bound to the top level
// depends only on the top level's ports
`default_nettype none
module stlx_checker (
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        m_axis_tvalid,
  input wire logic        m_axis_tready,
  input wire logic [39:0] m_axis_tdata,
  input wire logic [9:0]  m_axis_tuser,
  input wire logic        m_axis_tlast
);

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("result changed while stalled");

  a_text_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> !(m_axis_tuser[0] && m_axis_tuser[1]))
    else $error("text byte also closes a token");

  a_err_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser[9:8] != 2'd0 |-> m_axis_tlast && !m_axis_tuser[1])
    else $error("error result not last of its transfer");

  a_eof_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser[1] && m_axis_tuser[7:2] == 6'd34 |-> m_axis_tlast)
    else $error("eof token not last");

endmodule

bind script_token_lexer_unit stlx_checker u_stlx_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser),
  .m_axis_tlast  (m_axis_tlast)
);
`default_nettype wire

### verif/tb_top.sv
// self-checking testbench for script_token_lexer_unit: byte streams in, token results out
// depends on stlx_pkg (types and codes) and the lexer rtl; a scoreboard class predicts results
`timescale 1ns / 100ps
`default_nettype none

class lex_scoreboard;
  localparam logic [5:0] SIGN_BASE = 6'd7;
  localparam logic [5:0] NO_KIND   = 6'd0;
  localparam int MAX_PER_BYTE = 8;

  string sign_chars = ",.:;!?#@$()[]{}><=+-*/%~&|^";

  logic [2:0]     style;
  bit             ign_ws;
  logic [7:0]     ahead [3];
  int             ahead_n;
  stlx_pkg::mode_e mode;
  bit             dot_seen;
  int             skip_n;
  logic [15:0]    row, col;
  bit             locked;

  stlx_pkg::res_t pending_tokens[$];
  stlx_pkg::res_t step_res[$];
  int             fails;
  int             matched;
  int             err_seen;

  function new();
    style = 0;
    ign_ws = 0;
    locked = 0;
    fails = 0;
    matched = 0;
    err_seen = 0;
    clear_state();
  endfunction

  function void clear_state();
    ahead = '{default: 8'h00};
    ahead_n = 0;
    mode = stlx_pkg::M_IDLE;
    dot_seen = 0;
    skip_n = 0;
    row = 16'd1;
    col = 16'd1;
  endfunction

  function void set_reg(logic idx, logic [2:0] val);
    if (idx == stlx_pkg::REG_STYLE) style = val;
    else ign_ws = val[0];
  endfunction

  function void emit(logic [7:0] ch, bit txt, bit tend, logic [5:0] kind, logic [1:0] err);
    stlx_pkg::res_t r;
    if (step_res.size() >= MAX_PER_BYTE) return;
    r.ch = ch;
    r.txt = txt;
    r.tend = tend;
    r.kind = kind;
    r.row = row;
    r.col = col;
    r.err = err;
    r.last = 1'b0;
    step_res = {step_res, r};
  endfunction

  function void bump(logic [7:0] b);
    if (col != 16'hFFFF) col++;
    if (b == stlx_pkg::CH_LF) begin
      col = 16'd1;
      if (row != 16'hFFFF) row++;
    end
  endfunction

  function bit word_char(logic [7:0] c);
    return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z") || c == "_";
  endfunction

  function bit num_char(logic [7:0] c);
    return c >= "0" && c <= "9";
  endfunction

  function void white(logic [7:0] b);
    if (ign_ws) return;
    if (b == stlx_pkg::CH_SP) emit(b, 0, 1, stlx_pkg::K_BLANK, stlx_pkg::ERR_NONE);
    else if (b == stlx_pkg::CH_TAB) emit(b, 0, 1, stlx_pkg::K_TAB, stlx_pkg::ERR_NONE);
    else if (b == stlx_pkg::CH_LF) emit(b, 0, 1, stlx_pkg::K_NL, stlx_pkg::ERR_NONE);
  endfunction

  function bit raise(logic [1:0] code);
    emit(8'h00, 0, 0, NO_KIND, code);
    locked = 1;
    return 0;
  endfunction

  // judge one byte with three bytes of lookahead; 0 when an error was raised
  function bit judge(logic [7:0] b, logic [7:0] n1, logic [7:0] n2, logic [7:0] n3);
    logic [7:0] c;
    if (skip_n > 0) begin
      skip_n--;
      bump(b);
      return 1;
    end
    bump(b);
    if (mode == stlx_pkg::M_LINE) begin
      if (b == stlx_pkg::CH_LF) begin
        mode = stlx_pkg::M_IDLE;
        white(b);
      end
      return 1;
    end
    if (mode == stlx_pkg::M_BLOCK) begin
      if (style == stlx_pkg::STYLE_HTML) begin
        if (b == stlx_pkg::CH_DASH && n1 == stlx_pkg::CH_DASH && n2 == stlx_pkg::CH_GT) begin
          mode = stlx_pkg::M_IDLE;
          skip_n = 2;
        end
      end else if (b == stlx_pkg::CH_STAR && n1 == stlx_pkg::CH_SLASH) begin
        mode = stlx_pkg::M_IDLE;
        skip_n = 1;
      end
      return 1;
    end
    if (mode == stlx_pkg::M_ESC) begin
      if (b == stlx_pkg::CH_LC_T) c = stlx_pkg::CH_TAB;
      else if (b == stlx_pkg::CH_LC_N) c = stlx_pkg::CH_LF;
      else if (b == stlx_pkg::CH_DQ) c = stlx_pkg::CH_DQ;
      else return raise(stlx_pkg::ERR_ESCAPE);
      emit(c, 1, 0, NO_KIND, stlx_pkg::ERR_NONE);
      mode = stlx_pkg::M_STR;
      return 1;
    end
    if (mode == stlx_pkg::M_STR) begin
      if (b == stlx_pkg::CH_BSL) mode = stlx_pkg::M_ESC;
      else if (b == stlx_pkg::CH_DQ) begin
        mode = stlx_pkg::M_IDLE;
        emit(8'h00, 0, 1, stlx_pkg::K_STR, stlx_pkg::ERR_NONE);
      end else emit(b, 1, 0, NO_KIND, stlx_pkg::ERR_NONE);
      return 1;
    end
    if (b == stlx_pkg::CH_DQ) begin
      mode = stlx_pkg::M_STR;
      return 1;
    end
    if (style == stlx_pkg::STYLE_C && b == stlx_pkg::CH_SLASH &&
        (n1 == stlx_pkg::CH_SLASH || n1 == stlx_pkg::CH_STAR)) begin
      mode = (n1 == stlx_pkg::CH_SLASH) ? stlx_pkg::M_LINE : stlx_pkg::M_BLOCK;
      skip_n = 1;
      return 1;
    end
    if (style == stlx_pkg::STYLE_HTML && b == stlx_pkg::CH_LT && n1 == stlx_pkg::CH_BANG &&
        n2 == stlx_pkg::CH_DASH && n3 == stlx_pkg::CH_DASH) begin
      mode = stlx_pkg::M_BLOCK;
      skip_n = 3;
      return 1;
    end
    if ((style == stlx_pkg::STYLE_HASH && b == stlx_pkg::CH_HASH) ||
        (style == stlx_pkg::STYLE_SEMI && b == stlx_pkg::CH_SEMI)) begin
      mode = stlx_pkg::M_LINE;
      return 1;
    end
    if (b == stlx_pkg::CH_SP || b == stlx_pkg::CH_TAB || b == stlx_pkg::CH_CR ||
        b == stlx_pkg::CH_LF) begin
      white(b);
      return 1;
    end
    if (mode != stlx_pkg::M_NAME && word_char(b)) mode = stlx_pkg::M_NAME;
    if (mode == stlx_pkg::M_NAME) begin
      emit(b, 1, 0, NO_KIND, stlx_pkg::ERR_NONE);
      if (!word_char(n1) && !num_char(n1)) begin
        mode = stlx_pkg::M_IDLE;
        emit(8'h00, 0, 1, stlx_pkg::K_NAME, stlx_pkg::ERR_NONE);
      end
      return 1;
    end
    if (mode != stlx_pkg::M_NUM && (num_char(b) || (b == stlx_pkg::CH_DOT && num_char(n1))))
    begin
      mode = stlx_pkg::M_NUM;
      dot_seen = 0;
    end
    if (mode == stlx_pkg::M_NUM) begin
      if (b == stlx_pkg::CH_DOT) begin
        if (dot_seen) return raise(stlx_pkg::ERR_TWO_DOT);
        dot_seen = 1;
        if (!num_char(n1)) return raise(stlx_pkg::ERR_DOT);
        emit(b, 1, 0, NO_KIND, stlx_pkg::ERR_NONE);
      end else begin
        emit(b, 1, 0, NO_KIND, stlx_pkg::ERR_NONE);
        if (!num_char(n1) && n1 != stlx_pkg::CH_DOT) begin
          mode = stlx_pkg::M_IDLE;
          emit(8'h00, 0, 1, dot_seen ? stlx_pkg::K_FLT : stlx_pkg::K_INT, stlx_pkg::ERR_NONE);
        end
      end
      return 1;
    end
    for (int i = 0; i < 27; i++) begin
      if (b == sign_chars[i]) begin
        emit(b, 0, 1, SIGN_BASE + 6'(i), stlx_pkg::ERR_NONE);
        break;
      end
    end
    return 1;
  endfunction

  // called for every input transfer
  function void note_input(logic [7:0] b, bit last);
    logic [7:0] buf_q [7];
    int cnt;
    bit ok;
    if (locked) return;
    step_res.delete();
    ok = 1;
    if (!last) begin
      if (ahead_n < 3) begin
        ahead[ahead_n] = b;
        ahead_n++;
        return;
      end
      ok = judge(ahead[0], ahead[1], ahead[2], b);
      ahead[0] = ahead[1];
      ahead[1] = ahead[2];
      ahead[2] = b;
    end else begin
      buf_q = '{default: 8'h00};
      cnt = ahead_n;
      for (int i = 0; i < cnt; i++) buf_q[i] = ahead[i];
      buf_q[cnt] = b;
      cnt++;
      for (int i = 0; i < cnt && ok; i++)
        ok = judge(buf_q[i], buf_q[i+1], buf_q[i+2], buf_q[i+3]);
      // an escape still open at the end of text is a bad escape
      if (ok && mode == stlx_pkg::M_ESC && skip_n == 0) ok = raise(stlx_pkg::ERR_ESCAPE);
      if (ok) begin
        emit(8'h00, 0, 1, stlx_pkg::K_EOF, stlx_pkg::ERR_NONE);
        clear_state();
      end
    end
    if (step_res.size() > 0) step_res[$].last = 1'b1;
    pending_tokens = {pending_tokens, step_res};
  endfunction

  function void field_diff(string fname, longint unsigned e, longint unsigned a);
    $display("%0t: mismatch on %s: expected %0h, got %0h", $time, fname, e, a);
  endfunction

  // called for every output transfer
  function void check_result(stlx_pkg::res_t a);
    stlx_pkg::res_t e;
    if (pending_tokens.size() == 0) begin
      $display("%0t: unexpected result: expected none, got %p", $time, a);
      fails++;
      return;
    end
    e = pending_tokens.pop_front();
    if (a != e) begin
      fails++;
      if (a.ch != e.ch) field_diff("out_char", e.ch, a.ch);
      if (a.txt != e.txt) field_diff("is_text", e.txt, a.txt);
      if (a.tend != e.tend) field_diff("token_end", e.tend, a.tend);
      if (a.kind != e.kind) field_diff("token_kind", e.kind, a.kind);
      if (a.row != e.row) field_diff("row_pos", e.row, a.row);
      if (a.col != e.col) field_diff("col_pos", e.col, a.col);
      if (a.err != e.err) field_diff("error_code", e.err, a.err);
      if (a.last != e.last) field_diff("run_last", e.last, a.last);
    end else matched++;
    if (e.err != stlx_pkg::ERR_NONE) err_seen++;
  endfunction
endclass

module tb_top;
  import stlx_pkg::*;

  localparam int STALL_LIMIT = 4000;
  localparam int DRAIN_CYCLES = 16;
  localparam int RANDOM_ITEMS = 380;

  logic        clk_i;
  logic        rst_ni;
  logic        cfg_we_i;
  logic        cfg_idx_i;
  logic [2:0]  cfg_wdata_i;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata;   // in_char
  logic        s_axis_tlast;   // in_last
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [39:0] m_axis_tdata;   // out_char, row_pos, col_pos
  logic [9:0]  m_axis_tuser;   // is_text, token_end, token_kind, error_code
  logic        m_axis_tlast;   // run_last

  lex_scoreboard sb = new();

  logic [7:0] text_q[$];
  int  bytes_sent;
  int  hold_cycles;
  bit  quiet_phase;
  int  idle_cycles;
  logic [2:0] cur_style;

  script_token_lexer_unit uut (.*);

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  // output side: random ready with occasional long hold-offs
  initial begin
    int stall;
    stall = 0;
    m_axis_tready = 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold_cycles > 0) begin
        hold_cycles--;
        m_axis_tready = 1'b0;
      end else if (quiet_phase) m_axis_tready = 1'b1;
      else if (stall > 0) begin
        stall--;
        m_axis_tready = 1'b0;
      end else begin
        stall = pick_gap();
        m_axis_tready = (stall == 0);
      end
    end
  end

  always @(posedge clk_i) begin
    stlx_pkg::res_t r;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      r.ch = m_axis_tdata[7:0];
      r.row = m_axis_tdata[23:8];
      r.col = m_axis_tdata[39:24];
      r.txt = m_axis_tuser[0];
      r.tend = m_axis_tuser[1];
      r.kind = m_axis_tuser[7:2];
      r.err = m_axis_tuser[9:8];
      r.last = m_axis_tlast;
      sb.check_result(r);
    end
  end

  // watchdog on cycles without any transfer
  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles > STALL_LIMIT) begin
      $display("%0t: no transfer for %0d cycles", $time, idle_cycles);
      $display("Some tests failed");
      $finish;
    end
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  task automatic send_byte(logic [7:0] b, bit last);
    int g;
    s_axis_tvalid = 1'b1;
    s_axis_tdata = b;
    s_axis_tlast = last;
    do @(posedge clk_i); while (!s_axis_tready);
    sb.note_input(b, last);
    bytes_sent++;
    @(negedge clk_i);
    s_axis_tvalid = 1'b0;
    g = quiet_phase ? 0 : pick_gap();
    repeat (g) @(negedge clk_i);
  endtask

  task automatic send_text();
    foreach (text_q[i]) send_byte(text_q[i], i == text_q.size() - 1);
    text_q.delete();
  endtask

  task automatic add_byte(logic [7:0] b);
    text_q = {text_q, b};
  endtask

  task automatic push_str(string s);
    for (int i = 0; i < s.len(); i++) add_byte(s[i]);
  endtask

  // idle block before a register write; trailing no-result bytes may still be in flight
  task automatic write_reg(logic idx, logic [2:0] val);
    while (sb.pending_tokens.size() > 0) @(negedge clk_i);
    repeat (DRAIN_CYCLES) @(negedge clk_i);
    cfg_we_i = 1'b1;
    cfg_idx_i = idx;
    cfg_wdata_i = val;
    sb.set_reg(idx, val);
    if (idx == REG_STYLE) cur_style = val;
    @(negedge clk_i);
    cfg_we_i = 1'b0;
  endtask

  // bytes that cannot start a dot, quote or escape problem
  function automatic logic [7:0] safe_byte();
    logic [7:0] b;
    do b = 8'($urandom);
    while (b == CH_DQ || b == CH_BSL || b == CH_DOT || (b >= "0" && b <= "9"));
    return b;
  endfunction

  function automatic logic [7:0] letter();
    string al = "abcdefghijklmnopqrstuvwxyzABCDEFGHIJKLMNOPQRSTUVWXYZ_";
    return al[$urandom_range(0, al.len() - 1)];
  endfunction

  function automatic logic [7:0] white_byte();
    logic [7:0] w[4] = '{CH_SP, CH_TAB, CH_CR, CH_LF};
    return w[$urandom_range(0, 3)];
  endfunction

  task automatic push_digits();
    repeat ($urandom_range(1, 4)) add_byte(8'("0") + 8'($urandom_range(0, 9)));
  endtask

  task automatic push_comment_body();
    repeat ($urandom_range(0, 5)) add_byte($urandom_range(0, 3) == 0 ? CH_SP : letter());
  endtask

  // one well-formed token or piece of noise, appended to the text
  task automatic push_token();
    string signs = ",:;!?#@$()[]{}><=+-*/%~&|^";
    logic [7:0] esc[3] = '{CH_LC_T, CH_LC_N, CH_DQ};
    case ($urandom_range(0, 9))
      0, 1: begin
        add_byte(letter());
        repeat ($urandom_range(0, 5))
          add_byte($urandom_range(0, 3) == 0 ? 8'("0") + 8'($urandom_range(0, 9))
                                             : letter());
      end
      2: begin
        push_digits();
        add_byte(white_byte());
      end
      3: begin
        push_digits();
        add_byte(CH_DOT);
        push_digits();
        add_byte(white_byte());
      end
      4: begin
        add_byte(CH_DQ);
        repeat ($urandom_range(0, 6)) begin
          if ($urandom_range(0, 4) == 0) begin
            add_byte(CH_BSL);
            add_byte(esc[$urandom_range(0, 2)]);
          end else add_byte(safe_byte());
        end
        add_byte(CH_DQ);
      end
      5: add_byte(white_byte());
      6: add_byte(signs[$urandom_range(0, signs.len() - 1)]);
      7: begin
        case (cur_style)
          STYLE_C: begin
            if ($urandom_range(0, 1)) begin
              push_str("//");
              push_comment_body();
              add_byte(CH_LF);
            end else begin
              push_str("/*");
              push_comment_body();
              push_str("*/");
            end
          end
          STYLE_HTML: begin
            push_str("<!--");
            push_comment_body();
            push_str("-->");
          end
          STYLE_HASH, STYLE_SEMI: begin
            add_byte(cur_style == STYLE_HASH ? CH_HASH : CH_SEMI);
            push_comment_body();
            add_byte(CH_LF);
          end
          default: push_str("/* x */");
        endcase
      end
      default: add_byte(safe_byte());
    endcase
  endtask

  initial begin
    int sent_mark;
    logic [2:0] st;
    rst_ni = 1'b0;
    cfg_we_i = 1'b0;
    cfg_idx_i = REG_STYLE;
    cfg_wdata_i = '0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata = '0;
    s_axis_tlast = 1'b0;
    bytes_sent = 0;
    hold_cycles = 0;
    quiet_phase = 0;
    idle_cycles = 0;
    cur_style = '0;
    repeat (3) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // short texts that end before the lookahead fills
    push_str("A");
    send_text();
    push_str("z9");
    send_text();

    // names, numbers, escapes, odd bytes and C comments
    write_reg(REG_STYLE, STYLE_C);
    push_str("_Zz 09 1.5 .7\"\\t\\n\\\"\" ?/*x*/y//q");
    add_byte(8'h00);
    add_byte(8'hFF);
    add_byte(CH_CR);
    add_byte(CH_LF);
    push_str(". ");
    send_text();

    write_reg(REG_STYLE, STYLE_HTML);
    push_str("<!--a-->b");
    send_text();

    // random phases across all style values and both whitespace settings
    sent_mark = bytes_sent;
    for (int p = 0; p < 8 || bytes_sent - sent_mark < RANDOM_ITEMS; p++) begin
      st = (p < 8) ? 3'(p) : 3'($urandom_range(0, 7));
      write_reg(REG_STYLE, st);
      write_reg(REG_IGNWS, 3'(p % 3 == 1));
      quiet_phase = (p % 4 == 3);
      repeat ($urandom_range(1, 2)) begin
        repeat ($urandom_range(3, 8)) push_token();
        if (p == 5) hold_cycles = 300;
        send_text();
      end
      quiet_phase = 0;
    end

    // one error at the very end, since an error locks the block until reset
    write_reg(REG_STYLE, 3'd0);
    write_reg(REG_IGNWS, 3'd0);
    case ($urandom_range(0, 3))
      0: push_str("\"a\\q  ");
      1: push_str("1.2.3 ");
      2: push_str("7. x ");
      default: push_str("\"a\\");
    endcase
    send_text();
    push_str("ignored");
    send_text();

    while (sb.pending_tokens.size() > 0) @(negedge clk_i);
    repeat (DRAIN_CYCLES) @(negedge clk_i);
    $display("run covered %0d input bytes, %0d results matched, %0d error results",
             bytes_sent, sb.matched, sb.err_seen);
    $display("style values 0 to 7, whitespace on and off, long output stalls and end flushes");
    if (sb.fails == 0) $display("All tests passed");
    else $display("Some tests failed");
    $finish;
  end
endmodule

`default_nettype wire
